[design/gmakf_pkg.sv]
`timescale 1ns / 1ps

package gmakf_pkg;

    // default fraction bits of the fixed-point format
    localparam int FRAC_BITS_DEF = 16;

    // field widths
    localparam int CFG_W        = 31;
    localparam int CFG_IDX_W    = 3;
    localparam int DT_W         = 17;
    localparam int RATE_W       = 28;
    localparam int HEAD_W       = 25;
    localparam int VAL_W        = 32;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 96;

    // register reset values
    localparam logic [DT_W-1:0]  RST_STEP_TIME   = DT_W'(1311);
    localparam logic [CFG_W-1:0] RST_Q_ANGLE     = CFG_W'(655);
    localparam logic [CFG_W-1:0] RST_Q_GYRO_BIAS = CFG_W'(7);
    localparam logic [CFG_W-1:0] RST_Q_MAG_BIAS  = CFG_W'(655);
    localparam logic [CFG_W-1:0] RST_MEAS_NOISE  = CFG_W'(1638400);
    localparam logic [CFG_W-1:0] RST_P0_ANGLE    = CFG_W'(655360);
    localparam logic [CFG_W-1:0] RST_P0_GYRO     = CFG_W'(65536);
    localparam logic [CFG_W-1:0] RST_P0_MAG      = CFG_W'(327680);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_TIME   = 3'd0,
        REG_Q_ANGLE     = 3'd1,
        REG_Q_GYRO_BIAS = 3'd2,
        REG_Q_MAG_BIAS  = 3'd3,
        REG_MEAS_NOISE  = 3'd4,
        REG_P0_ANGLE    = 3'd5,
        REG_P0_GYRO     = 3'd6,
        REG_P0_MAG      = 3'd7
    } t_cfg_idx;

    // multiply / write-back micro-operations, in issue order
    typedef enum logic [4:0] {
        OP_ANGLE_PRED = 5'd0,
        OP_P0A        = 5'd1,
        OP_P1         = 5'd2,
        OP_P2         = 5'd3,
        OP_P0B        = 5'd4,
        OP_P3         = 5'd5,
        OP_P6         = 5'd6,
        OP_QADD       = 5'd7,
        OP_ANG_UPD    = 5'd8,
        OP_GB_UPD     = 5'd9,
        OP_MB_UPD     = 5'd10,
        OP_P00        = 5'd11,
        OP_P01        = 5'd12,
        OP_P02        = 5'd13,
        OP_P10        = 5'd14,
        OP_P11        = 5'd15,
        OP_P12        = 5'd16,
        OP_P20        = 5'd17,
        OP_P21        = 5'd18,
        OP_P22        = 5'd19
    } t_op;

    typedef struct packed {
        logic       load;
        logic       start_init;
        logic       mul;
        logic       wb;
        logic       prep;
        logic       div_start;
        logic [1:0] div_idx;
        t_op        op;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic s_pos;
        logic div_busy;
    } t_sts;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [67:0] v);
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        hi = 68'sh7fffffff;
        lo = -68'sh80000000;
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[VAL_W-1:0];
    endfunction

endpackage

[design/gmakf_ctrl.sv]
`timescale 1ns / 1ps

module gmakf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_kind,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output gmakf_pkg::t_cmd   o_cmd,
    input  gmakf_pkg::t_sts   i_sts
);
    import gmakf_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_START  = 9'b000000010,
        S_MUL    = 9'b000000100,
        S_WB     = 9'b000001000,
        S_PREP   = 9'b000010000,
        S_CHK    = 9'b000100000,
        S_DSTART = 9'b001000000,
        S_DIV    = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state     r_state, n_state;
    t_op        r_op, n_op;
    logic [1:0] r_div_idx, n_div_idx;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_div_idx   = r_div_idx;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.op      = r_op;
        o_cmd.div_idx = r_div_idx;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_op       = OP_ANGLE_PRED;
                    n_state    = i_kind ? S_MUL : S_START;
                end
            end
            S_START: begin
                o_cmd.start_init = 1'b1;
                n_state          = S_OUT;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_WB;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                if (r_op == OP_QADD) begin
                    n_state = S_PREP;
                end else if (r_op == OP_P22) begin
                    n_state = S_OUT;
                end else begin
                    n_op    = t_op'(r_op + 5'd1);
                    n_state = S_MUL;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                n_div_idx = 2'd0;
                n_state   = i_sts.s_pos ? S_DSTART : S_OUT;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    if (r_div_idx == 2'd2) begin
                        n_op    = OP_ANG_UPD;
                        n_state = S_MUL;
                    end else begin
                        n_div_idx = r_div_idx + 2'd1;
                        n_state   = S_DSTART;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_ANGLE_PRED;
            r_div_idx   <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_div_idx   <= n_div_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

[design/gmakf_dp.sv]
`timescale 1ns / 1ps

module gmakf_dp #(
    parameter int FRAC_BITS = gmakf_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  gmakf_pkg::t_cmd                        i_cmd,
    output gmakf_pkg::t_sts                        o_sts,
    input  logic                                   i_cfg_we,
    input  logic [gmakf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [gmakf_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic signed [gmakf_pkg::RATE_W-1:0]    i_rate,
    input  logic signed [gmakf_pkg::HEAD_W-1:0]    i_head,
    output logic [gmakf_pkg::OUT_TDATA_W-1:0]      o_result
);
    import gmakf_pkg::*;

    localparam int WN = 34 + FRAC_BITS;      // dividend / quotient bits
    localparam int WD = 34;                  // divisor bits
    localparam int CW = $clog2(WN + 1);
    localparam logic signed [65:0] RND  = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [35:0] HALF = 36'sd180 <<< FRAC_BITS;
    localparam logic signed [35:0] FULL = 36'sd360 <<< FRAC_BITS;

    function automatic logic signed [67:0] xs(input logic signed [VAL_W-1:0] v);
        return 68'(v);
    endfunction

    function automatic logic signed [67:0] xu(input logic [CFG_W-1:0] v);
        return $signed({37'd0, v});
    endfunction

    function automatic logic signed [32:0] x33(input logic signed [VAL_W-1:0] v);
        return {v[VAL_W-1], v};
    endfunction

    // configuration
    logic [DT_W-1:0]  r_step_time;
    logic [CFG_W-1:0] r_q_ang, r_q_gb, r_q_mb, r_meas, r_p0a, r_p0g, r_p0m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= RST_STEP_TIME;
            r_q_ang     <= RST_Q_ANGLE;
            r_q_gb      <= RST_Q_GYRO_BIAS;
            r_q_mb      <= RST_Q_MAG_BIAS;
            r_meas      <= RST_MEAS_NOISE;
            r_p0a       <= RST_P0_ANGLE;
            r_p0g       <= RST_P0_GYRO;
            r_p0m       <= RST_P0_MAG;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STEP_TIME:   r_step_time <= i_cfg_wdata[DT_W-1:0];
                REG_Q_ANGLE:     r_q_ang     <= i_cfg_wdata;
                REG_Q_GYRO_BIAS: r_q_gb      <= i_cfg_wdata;
                REG_Q_MAG_BIAS:  r_q_mb      <= i_cfg_wdata;
                REG_MEAS_NOISE:  r_meas      <= i_cfg_wdata;
                REG_P0_ANGLE:    r_p0a       <= i_cfg_wdata;
                REG_P0_GYRO:     r_p0g       <= i_cfg_wdata;
                REG_P0_MAG:      r_p0m       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // filter state and scratch
    logic signed [RATE_W-1:0] r_rate;
    logic signed [HEAD_W-1:0] r_head;
    logic signed [VAL_W-1:0]  r_ang, r_gb, r_mb, r_y;
    logic signed [VAL_W-1:0]  r_p [9];
    logic signed [VAL_W-1:0]  r_k [3];
    logic signed [VAL_W-1:0]  r_h [3];
    logic signed [32:0]       r_num [3];
    logic signed [34:0]       r_s;
    logic signed [65:0]       r_prod;

    // shared multiplier operands
    logic signed [32:0] w_a, w_b, w_dt;
    assign w_dt = $signed({16'd0, r_step_time});

    always_comb begin
        w_a = w_dt;
        w_b = '0;
        case (i_cmd.op)
            OP_ANGLE_PRED: begin
                w_a = $signed({{5{r_rate[RATE_W-1]}}, r_rate}) - x33(r_gb);
                w_b = w_dt;
            end
            OP_P0A:     w_b = x33(r_p[3]);
            OP_P1:      w_b = x33(r_p[4]);
            OP_P2:      w_b = x33(r_p[5]);
            OP_P0B:     w_b = x33(r_p[1]);
            OP_P3:      w_b = x33(r_p[4]);
            OP_P6:      w_b = x33(r_p[7]);
            OP_QADD:    w_b = '0;
            OP_ANG_UPD: begin w_a = x33(r_k[0]); w_b = x33(r_y); end
            OP_GB_UPD:  begin w_a = x33(r_k[1]); w_b = x33(r_y); end
            OP_MB_UPD:  begin w_a = x33(r_k[2]); w_b = x33(r_y); end
            OP_P00:     begin w_a = x33(r_k[0]); w_b = x33(r_h[0]); end
            OP_P01:     begin w_a = x33(r_k[0]); w_b = x33(r_h[1]); end
            OP_P02:     begin w_a = x33(r_k[0]); w_b = x33(r_h[2]); end
            OP_P10:     begin w_a = x33(r_k[1]); w_b = x33(r_h[0]); end
            OP_P11:     begin w_a = x33(r_k[1]); w_b = x33(r_h[1]); end
            OP_P12:     begin w_a = x33(r_k[1]); w_b = x33(r_h[2]); end
            OP_P20:     begin w_a = x33(r_k[2]); w_b = x33(r_h[0]); end
            OP_P21:     begin w_a = x33(r_k[2]); w_b = x33(r_h[1]); end
            OP_P22:     begin w_a = x33(r_k[2]); w_b = x33(r_h[2]); end
            default:    w_b = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= 66'(w_a) * 66'(w_b);
        end
    end

    // rounded product, round half up then floor shift
    logic signed [65:0] w_fm66;
    logic signed [67:0] w_fm;
    assign w_fm66 = (r_prod + RND) >>> FRAC_BITS;
    assign w_fm   = 68'(w_fm66);

    // innovation, wrapped by a full turn when beyond +/-180
    logic signed [35:0] w_y0, w_yw;
    assign w_y0 = 36'(r_head) - 36'(r_ang) - 36'(r_mb);
    always_comb begin
        w_yw = w_y0;
        if (w_y0 > HALF) begin
            w_yw = w_y0 - FULL;
        end else if (w_y0 < -HALF) begin
            w_yw = w_y0 + FULL;
        end
    end

    // serial restoring divider for the gains
    logic [WN-1:0]      r_dq, w_dq_n, w_dnd;
    logic [WD-1:0]      r_rem, w_rem_n;
    logic [CW-1:0]      r_dcnt;
    logic               r_dneg;
    logic [1:0]         r_didx;
    logic [WD:0]        w_rem_sh, w_dvs;
    logic               w_ge;
    logic signed [32:0] w_num;
    logic signed [33:0] w_num34, w_mag;
    logic [31:0]        w_qc;
    logic signed [VAL_W-1:0] w_k;

    always_comb begin
        case (i_cmd.div_idx)
            2'd0:    w_num = r_num[0];
            2'd1:    w_num = r_num[1];
            default: w_num = r_num[2];
        endcase
        w_num34 = 34'(w_num);
        w_mag   = w_num[32] ? -w_num34 : w_num34;
        w_dnd   = (WN'(w_mag[32:0]) << FRAC_BITS) + WN'(r_s[33:1]);
    end

    assign w_dvs    = {1'b0, r_s[WD-1:0]};
    assign w_rem_sh = {r_rem, r_dq[WN-1]};
    assign w_ge     = (w_rem_sh >= w_dvs);
    assign w_rem_n  = w_ge ? WD'(w_rem_sh - w_dvs) : w_rem_sh[WD-1:0];
    assign w_dq_n   = {r_dq[WN-2:0], w_ge};

    always_comb begin
        if (w_dq_n > WN'(33'h080000000)) begin
            w_qc = 32'h80000000;
        end else begin
            w_qc = w_dq_n[31:0];
        end
        if (r_dneg) begin
            w_k = -$signed(w_qc);
        end else if (w_qc[31]) begin
            w_k = 32'sh7fffffff;
        end else begin
            w_k = $signed(w_qc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dcnt <= CW'(WN);
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dq   <= w_dnd;
            r_rem  <= '0;
            r_dneg <= w_num[32];
            r_didx <= i_cmd.div_idx;
        end else if (r_dcnt != '0) begin
            r_dq  <= w_dq_n;
            r_rem <= w_rem_n;
            if (r_dcnt == CW'(1)) begin
                case (r_didx)
                    2'd0:    r_k[0] <= w_k;
                    2'd1:    r_k[1] <= w_k;
                    default: r_k[2] <= w_k;
                endcase
            end
        end
    end

    // state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang <= '0;
            r_gb  <= '0;
            r_mb  <= '0;
            for (int i = 0; i < 9; i++) begin
                r_p[i] <= '0;
            end
        end else if (i_cmd.start_init) begin
            r_ang <= '0;
            r_gb  <= '0;
            r_mb  <= 32'(r_head);
            for (int i = 0; i < 9; i++) begin
                r_p[i] <= '0;
            end
            r_p[0] <= $signed({1'b0, r_p0a});
            r_p[4] <= $signed({1'b0, r_p0g});
            r_p[8] <= $signed({1'b0, r_p0m});
        end else if (i_cmd.wb) begin
            case (i_cmd.op)
                OP_ANGLE_PRED: r_ang  <= sat32(xs(r_ang) + w_fm);
                OP_P0A:        r_p[0] <= sat32(xs(r_p[0]) - w_fm);
                OP_P1:         r_p[1] <= sat32(xs(r_p[1]) - w_fm);
                OP_P2:         r_p[2] <= sat32(xs(r_p[2]) - w_fm);
                OP_P0B:        r_p[0] <= sat32(xs(sat32(xs(r_p[0]) - w_fm)) + xu(r_q_ang));
                OP_P3:         r_p[3] <= sat32(xs(r_p[3]) - w_fm);
                OP_P6:         r_p[6] <= sat32(xs(r_p[6]) - w_fm);
                OP_QADD: begin
                    r_p[4] <= sat32(xs(r_p[4]) + xu(r_q_gb));
                    r_p[8] <= sat32(xs(r_p[8]) + xu(r_q_mb));
                end
                OP_ANG_UPD:    r_ang  <= sat32(xs(r_ang) + w_fm);
                OP_GB_UPD:     r_gb   <= sat32(xs(r_gb) + w_fm);
                OP_MB_UPD:     r_mb   <= sat32(xs(r_mb) + w_fm);
                OP_P00:        r_p[0] <= sat32(xs(r_p[0]) - w_fm);
                OP_P01:        r_p[1] <= sat32(xs(r_p[1]) - w_fm);
                OP_P02:        r_p[2] <= sat32(xs(r_p[2]) - w_fm);
                OP_P10:        r_p[3] <= sat32(xs(r_p[3]) - w_fm);
                OP_P11:        r_p[4] <= sat32(xs(r_p[4]) - w_fm);
                OP_P12:        r_p[5] <= sat32(xs(r_p[5]) - w_fm);
                OP_P20:        r_p[6] <= sat32(xs(r_p[6]) - w_fm);
                OP_P21:        r_p[7] <= sat32(xs(r_p[7]) - w_fm);
                OP_P22:        r_p[8] <= sat32(xs(r_p[8]) - w_fm);
                default: ;
            endcase
        end
    end

    // item capture, innovation prep and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rate <= i_rate;
            r_head <= i_head;
        end
        if (i_cmd.prep) begin
            r_y <= sat32(68'(w_yw));
            r_s <= 35'(r_p[0]) + 35'(r_p[8]) + (35'(r_p[2]) <<< 1)
                   + $signed({4'd0, r_meas});
            for (int j = 0; j < 3; j++) begin
                r_h[j]   <= sat32(xs(r_p[j]) + xs(r_p[6 + j]));
                r_num[j] <= 33'(r_p[3 * j]) + 33'(r_p[3 * j + 2]);
            end
        end
        if (i_cmd.out_load) begin
            o_result <= {r_mb, r_gb, r_ang};
        end
    end

    assign o_sts.s_pos    = !r_s[34] && (r_s != '0);
    assign o_sts.div_busy = (r_dcnt != '0);

endmodule

[design/gyro_mag_angle_kalman_filter_top.sv]
`timescale 1ns / 1ps

// Three-state Kalman filter (angle, gyro bias, magnetometer bias) in signed
// fixed point with FRAC_BITS fraction bits, Q16.16 by default. One item in
// flight at a time, a start beat (tuser 0) or a predict and update beat. In
// an update the gain divider dominates: it is a restoring divider giving
// one quotient bit a cycle over FRAC_BITS+34 bits, run once per gain. All
// products go through a single 33x33 multiplier with a register on its
// output. If the innovation variance is not positive the update is skipped.
// The result sits in an output register, so a beat waiting downstream does
// not hold up the accept of the next input once the current one is delivered
// to that register. Configuration writes take effect on the next edge and
// must only be made while idle.

module gyro_mag_angle_kalman_filter_top #(
    parameter int FRAC_BITS = gmakf_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // slave stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [27:0] gyro_rate, [52:28] heading, [55:53] zero
    input  logic [gmakf_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // [0] kind
    input  logic                                  i_s_axis_tuser,
    // master stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [31:0] angle_out, [63:32] gyro_bias_est, [95:64] mag_bias_est
    output logic [gmakf_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [gmakf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gmakf_pkg::CFG_W-1:0]           i_cfg_wdata
);
    import gmakf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    gmakf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_kind     (i_s_axis_tuser),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    gmakf_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rate      ($signed(i_s_axis_tdata[RATE_W-1:0])),
        .i_head      ($signed(i_s_axis_tdata[RATE_W+HEAD_W-1:RATE_W])),
        .o_result    (o_m_axis_tdata)
    );

endmodule

[design/gmakf_chk.sv]
`timescale 1ns / 1ps

module gmakf_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_s_axis_tvalid,
    input logic                                  o_s_axis_tready,
    input logic                                  o_m_axis_tvalid,
    input logic                                  i_m_axis_tready,
    input logic [gmakf_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result beat dropped or changed while stalled");

    // one item at a time: busy after accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while an item is in work");

    // a new result only appears while an item was being worked on
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result appeared with no item in work");

    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind gyro_mag_angle_kalman_filter_top gmakf_chk u_gmakf_chk (.*);
